@@ rtl/core/sfp_pkg.sv @@
// Package for the square-free part unit: widths, table entry and request types,
// and the state encodings of the sieve and factoring sequencers.
// Depends on nothing; every other file of the block takes names from here.
`default_nettype none

package sfp_pkg;

  // Values are factored over a table of 2^VALUE_BITS entries.
  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned TABLE_DEPTH = 1 << VALUE_BITS;
  localparam int unsigned IN_BITS     = 16;
  localparam int unsigned OUT_BITS    = 16;

  typedef logic [VALUE_BITS-1:0]          val_t;
  typedef logic [2*VALUE_BITS-1:0]        sq_t;
  typedef logic [IN_BITS-1:0]             in_t;
  typedef logic [OUT_BITS-1:0]            res_t;
  typedef logic [OUT_BITS+VALUE_BITS-1:0] prod_full_t;

  // One table entry: smallest prime factor of the index and the cofactor
  // index / spf. An entry with spf zero has not been reached by the sieve yet.
  typedef struct packed {
    val_t spf;
    val_t cof;
  } entry_t;

  // Memory access request from the sieve sequencer.
  typedef struct packed {
    logic   we;
    val_t   waddr;
    entry_t wdata;
    val_t   raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_OUTER_RD,
    SV_OUTER_CHK,
    SV_SQUARE,
    SV_INNER,
    SV_DONE
  } sieve_state_e;

  typedef enum logic [2:0] {
    FC_IDLE,
    FC_LOOK,
    FC_FLUSH_RUN,
    FC_FLUSH_LAST,
    FC_DONE
  } fac_state_e;

endpackage

`default_nettype wire

@@ rtl/core/sfp_in_if.sv @@
// Input channel of the square-free part unit: valid/ready plus the value word.
// Depends on sfp_pkg for the payload type.
`default_nettype none

interface sfp_in_if;
  logic         valid;
  logic         ready;
  sfp_pkg::in_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfp_out_if.sv @@
// Output channel of the square-free part unit: valid/ready plus the result word.
// Depends on sfp_pkg for the payload type.
`default_nettype none

interface sfp_out_if;
  logic          valid;
  logic          ready;
  sfp_pkg::res_t square_free_part;

  modport source (output valid, output square_free_part, input ready);
  modport sink   (input valid, input square_free_part, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfp_table.sv @@
// Smallest-prime-factor table: one synchronous memory, one write and one read
// port, registered read data. Depends on sfp_pkg.
`default_nettype none

module sfp_table (
  input  wire logic              clk_i,
  input  wire logic              fill_done_i,
  input  wire sfp_pkg::mem_req_t sieve_req_i,
  input  wire sfp_pkg::val_t     fac_raddr_i,
  output sfp_pkg::entry_t        rd_data_o
);

  sfp_pkg::entry_t mem [sfp_pkg::TABLE_DEPTH];
  sfp_pkg::val_t   raddr;
  sfp_pkg::entry_t rd_data_q;

  // The sieve owns the read port until the fill is over, then the factoring side.
  assign raddr = fill_done_i ? fac_raddr_i : sieve_req_i.raddr;

  // Only the sieve ever writes.
  always_ff @(posedge clk_i) begin
    if (sieve_req_i.we && !fill_done_i) begin
      mem[sieve_req_i.waddr] <= sieve_req_i.wdata;
    end
    rd_data_q <= mem[raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/sfp_sieve.sv @@
// Sieve sequencer: clears the table after reset, then fills every entry from 2
// up with its smallest prime factor and cofactor. Depends on sfp_pkg.
`default_nettype none

module sfp_sieve (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sfp_pkg::entry_t  rd_data_i,
  output sfp_pkg::mem_req_t     req_o,
  output logic                  done_o
);

  sfp_pkg::sieve_state_e state_q, state_d;
  sfp_pkg::val_t         cnt_q, cnt_d;   // clear address, then the outer index
  sfp_pkg::sq_t          j_q, j_d;       // inner multiple of the current prime
  sfp_pkg::val_t         cof_q, cof_d;   // j_q divided by the current prime
  sfp_pkg::val_t         wa_q, wa_d;     // address of the read in flight
  sfp_pkg::val_t         wc_q, wc_d;     // cofactor belonging to that address
  logic                  pend_q, pend_d; // a read of a multiple is in flight
  logic                  in_range;

  assign in_range = (j_q[2*sfp_pkg::VALUE_BITS-1:sfp_pkg::VALUE_BITS] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfp_pkg::SV_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    cof_q <= cof_d;
    wa_q  <= wa_d;
    wc_q  <= wc_d;
  end

  // Next state and memory requests.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    cof_d   = cof_q;
    wa_d    = wa_q;
    wc_d    = wc_q;
    pend_d  = pend_q;
    req_o   = '0;
    req_o.raddr = cnt_q;

    case (state_q)
      sfp_pkg::SV_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.waddr = cnt_q;
        cnt_d       = cnt_q + sfp_pkg::val_t'(1);
        if (cnt_q == '1) begin
          cnt_d   = sfp_pkg::val_t'(2);
          state_d = sfp_pkg::SV_OUTER_RD;
        end
      end

      sfp_pkg::SV_OUTER_RD: begin
        state_d = sfp_pkg::SV_OUTER_CHK;
      end

      // An index not yet marked is a prime: it is its own factor.
      sfp_pkg::SV_OUTER_CHK: begin
        if (rd_data_i.spf == '0) begin
          req_o.we        = 1'b1;
          req_o.waddr     = cnt_q;
          req_o.wdata.spf = cnt_q;
          req_o.wdata.cof = sfp_pkg::val_t'(1);
          state_d         = sfp_pkg::SV_SQUARE;
        end else if (cnt_q == '1) begin
          state_d = sfp_pkg::SV_DONE;
        end else begin
          cnt_d   = cnt_q + sfp_pkg::val_t'(1);
          state_d = sfp_pkg::SV_OUTER_RD;
        end
      end

      // Marking starts at the square of the prime.
      sfp_pkg::SV_SQUARE: begin
        j_d     = sfp_pkg::sq_t'(cnt_q) * sfp_pkg::sq_t'(cnt_q);
        cof_d   = cnt_q;
        pend_d  = 1'b0;
        state_d = sfp_pkg::SV_INNER;
      end

      // Read a multiple each cycle; in the next cycle write it if still unmarked.
      sfp_pkg::SV_INNER: begin
        if (pend_q && (rd_data_i.spf == '0)) begin
          req_o.we        = 1'b1;
          req_o.waddr     = wa_q;
          req_o.wdata.spf = cnt_q;
          req_o.wdata.cof = wc_q;
        end
        if (in_range) begin
          req_o.raddr = j_q[sfp_pkg::VALUE_BITS-1:0];
          wa_d        = j_q[sfp_pkg::VALUE_BITS-1:0];
          wc_d        = cof_q;
          pend_d      = 1'b1;
          j_d         = j_q + sfp_pkg::sq_t'(cnt_q);
          cof_d       = cof_q + sfp_pkg::val_t'(1);
        end else begin
          pend_d = 1'b0;
          if (cnt_q == '1) begin
            state_d = sfp_pkg::SV_DONE;
          end else begin
            cnt_d   = cnt_q + sfp_pkg::val_t'(1);
            state_d = sfp_pkg::SV_OUTER_RD;
          end
        end
      end

      sfp_pkg::SV_DONE: begin
        state_d = sfp_pkg::SV_DONE;
      end

      default: begin
        state_d = sfp_pkg::SV_CLEAR;
      end
    endcase
  end

  assign done_o = (state_q == sfp_pkg::SV_DONE);

endmodule

`default_nettype wire

@@ rtl/core/sfp_factor.sv @@
// Factoring sequencer: follows the cofactor chain through the table, keeps the
// parity of each prime's exponent and multiplies up the odd ones. Holds the
// output register. Depends on sfp_pkg, sfp_in_if and sfp_out_if.
`default_nettype none

module sfp_factor (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            enable_i,
  input  wire sfp_pkg::entry_t rd_data_i,
  output sfp_pkg::val_t        raddr_o,
  sfp_in_if.sink               in_i,
  sfp_out_if.source            out_o
);

  sfp_pkg::fac_state_e  state_q, state_d;
  sfp_pkg::val_t        run_p_q, run_p_d;  // prime of the current run
  logic                 odd_q, odd_d;      // its exponent so far is odd
  sfp_pkg::val_t        pend_q, pend_d;    // factor to multiply in next cycle
  sfp_pkg::res_t        prod_q, prod_d;
  logic                 out_valid_q, out_valid_d;
  sfp_pkg::res_t        out_data_q, out_data_d;
  sfp_pkg::val_t        x;
  sfp_pkg::val_t        run_flush;
  sfp_pkg::prod_full_t  prod_full;
  sfp_pkg::res_t        prod_mul;

  // Input wraps to the table width.
  assign x         = sfp_pkg::val_t'(in_i.value);
  assign run_flush = odd_q ? run_p_q : sfp_pkg::val_t'(1);
  assign prod_full = sfp_pkg::prod_full_t'(prod_q) * sfp_pkg::prod_full_t'(pend_q);
  assign prod_mul  = sfp_pkg::res_t'(prod_full);

  assign in_i.ready             = enable_i && (state_q == sfp_pkg::FC_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.square_free_part = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfp_pkg::FC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_p_q    <= run_p_d;
    odd_q      <= odd_d;
    pend_q     <= pend_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  // Next state, lookup address and output register.
  always_comb begin
    state_d     = state_q;
    run_p_d     = run_p_q;
    odd_d       = odd_q;
    pend_d      = pend_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    raddr_o     = rd_data_i.cof;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      sfp_pkg::FC_IDLE: begin
        raddr_o = x;
        if (in_i.valid && in_i.ready) begin
          run_p_d = '0;
          odd_d   = 1'b0;
          pend_d  = sfp_pkg::val_t'(1);
          prod_d  = sfp_pkg::res_t'(1);
          state_d = (x > sfp_pkg::val_t'(1)) ? sfp_pkg::FC_LOOK : sfp_pkg::FC_DONE;
        end
      end

      // One lookup per prime factor; the cofactor addresses the next lookup.
      sfp_pkg::FC_LOOK: begin
        prod_d = prod_mul;
        pend_d = sfp_pkg::val_t'(1);
        if (rd_data_i.spf < sfp_pkg::val_t'(2)) begin
          // No usable factor: close the open run and stop.
          pend_d  = run_flush;
          odd_d   = 1'b0;
          state_d = sfp_pkg::FC_FLUSH_RUN;
        end else begin
          if (rd_data_i.spf == run_p_q) begin
            odd_d = !odd_q;
          end else begin
            pend_d  = run_flush;
            run_p_d = rd_data_i.spf;
            odd_d   = 1'b1;
          end
          if (rd_data_i.cof < sfp_pkg::val_t'(2)) begin
            state_d = sfp_pkg::FC_FLUSH_RUN;
          end
        end
      end

      sfp_pkg::FC_FLUSH_RUN: begin
        prod_d  = prod_mul;
        pend_d  = run_flush;
        state_d = sfp_pkg::FC_FLUSH_LAST;
      end

      sfp_pkg::FC_FLUSH_LAST: begin
        prod_d  = prod_mul;
        state_d = sfp_pkg::FC_DONE;
      end

      // Wait for room in the output register.
      sfp_pkg::FC_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = prod_q;
          state_d     = sfp_pkg::FC_IDLE;
        end
      end

      default: begin
        state_d = sfp_pkg::FC_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/square_free_part_unit_core.sv @@
// Top level of the square-free part unit: sieve sequencer, factor table and
// factoring sequencer. Depends on sfp_pkg, sfp_in_if, sfp_out_if, sfp_table,
// sfp_sieve and sfp_factor.
//
//   Channel | Dir | Word              | Handshake
//   in_i    | in  | value (16 b)      | valid/ready, taken when both high
//   out_o   | out | square_free_part  | valid/ready, taken when both high
//
// After reset the table is cleared and then sieved; in_i.ready stays low until
// the fill is over. An accepted item takes one table lookup per prime factor
// counted with multiplicity (at most VALUE_BITS), then the states FC_FLUSH_RUN,
// FC_FLUSH_LAST and FC_DONE, where it waits for room in the output register;
// 0 and 1 go straight to FC_DONE. The single table read port sets this pace.
// One item is factored at a time; a result waiting in the output register does
// not block the next acceptance, only the next result.
`default_nettype none

module square_free_part_unit_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfp_in_if.sink    in_i,
  sfp_out_if.source out_o
);

  sfp_pkg::mem_req_t sieve_req;
  sfp_pkg::entry_t   rd_data;
  sfp_pkg::val_t     fac_raddr;
  logic              fill_done;

  sfp_sieve u_sieve (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_data_i (rd_data),
    .req_o     (sieve_req),
    .done_o    (fill_done)
  );

  sfp_table u_table (
    .clk_i       (clk_i),
    .fill_done_i (fill_done),
    .sieve_req_i (sieve_req),
    .fac_raddr_i (fac_raddr),
    .rd_data_o   (rd_data)
  );

  sfp_factor u_factor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .enable_i  (fill_done),
    .rd_data_i (rd_data),
    .raddr_o   (fac_raddr),
    .in_i      (in_i),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for square_free_part_unit_core: drives value words,
// predicts each square-free part from a smallest-prime-factor table of its own.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if and the RTL of the block.
module testbench;

  localparam int unsigned NUM_DIRECTED = 22;
  localparam int unsigned NUM_RANDOM   = 1700;
  // Words accepted at which each traffic phase ends.
  localparam int unsigned END_FREE     = NUM_DIRECTED + 200;
  localparam int unsigned END_SEND_GAP = NUM_DIRECTED + 550;
  localparam int unsigned END_RECV_GAP = NUM_DIRECTED + 900;
  localparam int unsigned END_BOTH_GAP = NUM_DIRECTED + 1250;
  // Long output hold-off that backs the block up to its input.
  localparam int unsigned HOLD_AT      = NUM_DIRECTED + 1400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * (sfp_pkg::VALUE_BITS + 4);

  localparam sfp_pkg::in_t DIRECTED_VALUES [NUM_DIRECTED] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd9, 16'd12, 16'd255, 16'd256,
    16'd1024, 16'd30030, 16'd32768, 16'd46189, 16'd49152, 16'd59049, 16'd61009,
    16'd64009, 16'd65025, 16'd65521, 16'd65534, 16'd65535
  };

  logic clk_i;
  logic rst_ni;

  sfp_in_if  in_bus ();
  sfp_out_if out_bus ();

  square_free_part_unit_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // Smallest prime factor of every table index; 0 and 1 map to themselves.
  int unsigned   least_prime [sfp_pkg::TABLE_DEPTH];
  sfp_pkg::in_t  value_queue [$];
  sfp_pkg::res_t sqfree_expected [$];
  int unsigned   values_sent;
  int unsigned   results_checked;
  int unsigned   mismatch_count;
  int unsigned   hold_left;
  bit            hold_done;

  function automatic void build_factor_table();
    longint unsigned j;
    for (int unsigned i = 0; i < sfp_pkg::TABLE_DEPTH; i++) least_prime[i] = 0;
    if (sfp_pkg::TABLE_DEPTH > 1) least_prime[1] = 1;
    for (int unsigned i = 2; i < sfp_pkg::TABLE_DEPTH; i++) begin
      if (least_prime[i] == 0) begin
        least_prime[i] = i;
        for (j = longint'(i) * i; j < sfp_pkg::TABLE_DEPTH; j += i) begin
          if (least_prime[j] == 0) least_prime[j] = i;
        end
      end
    end
  endfunction

  // Appends one word to the stimulus queue.
  function automatic void enqueue_value(sfp_pkg::in_t word);
    value_queue = {value_queue, word};
  endfunction

  // Product of the primes that divide the value an odd number of times.
  function automatic sfp_pkg::res_t sq_free_part_of(sfp_pkg::in_t value);
    int unsigned rest;
    int unsigned prime;
    int unsigned part;
    bit          odd;
    rest = value & (sfp_pkg::TABLE_DEPTH - 1);
    part = 1;
    while (rest > 1) begin
      prime = least_prime[rest];
      if (prime < 2) break;
      odd = 1'b0;
      while (rest % prime == 0) begin
        rest = rest / prime;
        odd  = !odd;
      end
      if (odd) part = part * prime;
    end
    return sfp_pkg::res_t'(part);
  endfunction

  // Random idle decision for one side, by traffic phase.
  function automatic bit holds_off(bit is_sender, int unsigned count);
    if (count < END_FREE) return 1'b0;
    if (count < END_SEND_GAP) return is_sender && ($urandom_range(99) < 84);
    if (count < END_RECV_GAP) return !is_sender && ($urandom_range(99) < 84);
    if (count < END_BOTH_GAP) return $urandom_range(99) < 15;
    return 1'b0;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver: offers queued words and records the expected part of each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.value <= '0;
      values_sent  <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        sqfree_expected = {sqfree_expected, sq_free_part_of(in_bus.value)};
        values_sent <= values_sent + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (value_queue.size() != 0 && !holds_off(1'b1, values_sent)) begin
          in_bus.valid <= 1'b1;
          in_bus.value <= value_queue.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once when enough words have gone in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && values_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_checked = results_checked + 1;
        if (sqfree_expected.size() == 0) begin
          $display("%0t: square_free_part expected none, got %0d",
                   $time, out_bus.square_free_part);
          mismatch_count = mismatch_count + 1;
        end else begin
          if (out_bus.square_free_part !== sqfree_expected[0]) begin
            $display("%0t: square_free_part expected %0d, got %0d",
                     $time, sqfree_expected[0], out_bus.square_free_part);
            mismatch_count = mismatch_count + 1;
          end
          void'(sqfree_expected.pop_front());
        end
      end
      out_bus.ready <= (hold_left == 0) && !holds_off(1'b0, values_sent);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned pick;
    int unsigned root;
    int unsigned scale;
    int unsigned prime;
    int unsigned product;
    in_bus.valid    = 1'b0;
    in_bus.value    = '0;
    out_bus.ready   = 1'b0;
    rst_ni          = 1'b0;
    results_checked = 0;
    mismatch_count  = 0;
    build_factor_table();

    foreach (DIRECTED_VALUES[i]) enqueue_value(DIRECTED_VALUES[i]);
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        enqueue_value(sfp_pkg::in_t'($urandom_range(65535)));
      end else if (pick < 6) begin
        enqueue_value(sfp_pkg::in_t'($urandom_range(255)));
      end else if (pick < 8) begin
        // A square times a cofactor that keeps it in 16 bits: even exponents must cancel.
        root  = $urandom_range(255, 1);
        scale = $urandom_range(65535 / (root * root), 1);
        enqueue_value(sfp_pkg::in_t'(root * root * scale));
      end else begin
        // Products of small primes with repeats.
        product = 1;
        repeat ($urandom_range(10, 1)) begin
          prime = least_prime[$urandom_range(200, 2)];
          if (product * prime <= 65535) product = product * prime;
        end
        enqueue_value(sfp_pkg::in_t'(product));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (value_queue.size() != 0 || in_bus.valid || sqfree_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sqfree_expected.size() != 0) begin
      $display("%0t: %0d square_free_part results never arrived",
               $time, sqfree_expected.size());
      mismatch_count = mismatch_count + 1;
    end
    $display("Covered %0d values (%0d directed, the rest random), %0d results checked,",
             values_sent, NUM_DIRECTED, results_checked);
    $display("under free flow, sender gaps, receiver stalls and one long output hold.");
    if (mismatch_count == 0) begin
      $display("square_free_part_unit_core: match");
    end else begin
      $display("square_free_part_unit_core: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(12 * 3000000);
    $display("square_free_part_unit_core: mismatch");
    $finish;
  end
endmodule
